>>> rtl/prbd_pkg.sv
// Package: shared types, constants and codes for the peer signal-strength bar display.
package prbd_pkg;

  localparam int unsigned DefMaxPeers  = 16;
  localparam int unsigned DefBarColumns = 8;
  localparam int unsigned DefBarHeight = 8;

  localparam logic [31:0] MAGIC_VALUE  = 32'h3152_4452;
  localparam logic [7:0]  MIN_LENGTH   = 8'd14;
  localparam logic [31:0] EXPIRE_RESET = 32'd10000;
  localparam logic [3:0]  KEEP_RESET   = 4'd7;
  localparam logic [3:0]  KEEP_MAX     = 4'd10;

  localparam logic signed [7:0] RSSI_LOW  = -8'sd100;
  localparam logic signed [7:0] RSSI_HIGH = -8'sd30;

  // x/70 as (x*RECIP70) >> 20, exact for x below 2^15
  localparam logic [14:0] RECIP70 = 15'd14980;
  // x/10 as (x*RECIP10) >> 16, exact for x below 2^11
  localparam logic [12:0] RECIP10 = 13'd6554;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_UPDATED   = 3'd1;
  localparam logic [2:0] ST_TOO_SHORT = 3'd2;
  localparam logic [2:0] ST_BAD_MAGIC = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_COLUMN    = 3'd5;

  localparam logic REG_EXPIRE = 1'b0;
  localparam logic REG_KEEP   = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [31:0]       now_ms;
    logic [47:0]       src_mac;
    logic              rssi_valid;
    logic signed [7:0] rssi_sample;
    logic [7:0]        packet_length;
    logic [31:0]       magic_word;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  column;
    logic [3:0]  bar_height;
    logic [15:0] bar_color;
    logic        blink_dots;
    logic        last;
  } result_t;

  typedef struct packed {
    logic insert;
    logic update;
    logic clear;
  } tbl_wr_t;

  typedef struct packed {
    logic              valid;
    logic              found;
    logic [2:0]        status;
    logic [2:0]        column;
    logic signed [7:0] strength;
    logic              dots;
    logic              last;
  } col_req_t;

endpackage

>>> rtl/prbd_table.sv
// Peer table: valid bits, addresses, strengths and last-seen times, one read and one write index.
module prbd_table
  import prbd_pkg::*;
#(
  parameter int unsigned MAX_PEERS = DefMaxPeers,
  localparam int unsigned IW = $clog2(MAX_PEERS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [IW-1:0]        rd_idx,
  output logic                 rd_valid,
  output logic [47:0]          rd_addr,
  output logic signed [7:0]    rd_strength,
  output logic [31:0]          rd_seen,
  input  tbl_wr_t              wr,
  input  logic [IW-1:0]        wr_idx,
  input  logic [47:0]          wr_addr,
  input  logic signed [7:0]    wr_strength,
  input  logic [31:0]          wr_seen
);

  logic [MAX_PEERS-1:0] valid;
  logic [47:0]          addr_mem     [MAX_PEERS];
  logic signed [7:0]    strength_mem [MAX_PEERS];
  logic [31:0]          seen_mem     [MAX_PEERS];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.insert) begin
      valid[wr_idx] <= 1'b1;
    end else if (wr.clear) begin
      valid[wr_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.insert) begin
      addr_mem[wr_idx] <= wr_addr;
    end
    if (wr.insert || wr.update) begin
      strength_mem[wr_idx] <= wr_strength;
      seen_mem[wr_idx]     <= wr_seen;
    end
  end

  assign rd_valid    = valid[rd_idx];
  assign rd_addr     = addr_mem[rd_idx];
  assign rd_strength = strength_mem[rd_idx];
  assign rd_seen     = seen_mem[rd_idx];

endmodule

>>> rtl/prbd_colbar.sv
// Result stage: bar height and RGB565 colour from a strength, registered onto the result ports.
module prbd_colbar
  import prbd_pkg::*;
#(
  parameter int unsigned BAR_HEIGHT = DefBarHeight
) (
  input  logic     clk,
  input  logic     rst,
  input  col_req_t req,
  output logic     result_valid,
  output result_t  result
);

  logic signed [7:0] clamped;
  logic [6:0]        d;
  logic [14:0]       hx;
  logic [14:0]       gx;
  logic [29:0]       hprod;
  logic [29:0]       gprod;
  logic [7:0]        g;
  logic [7:0]        r;
  logic [3:0]        h;

  always_comb begin
    if (req.strength < RSSI_LOW) begin
      clamped = RSSI_LOW;
    end else if (req.strength > RSSI_HIGH) begin
      clamped = RSSI_HIGH;
    end else begin
      clamped = req.strength;
    end
    d     = 7'(clamped - RSSI_LOW);
    hx    = 15'(d) * 15'(BAR_HEIGHT);
    gx    = (15'(d) << 8) - 15'(d);
    hprod = 30'(hx) * 30'(RECIP70);
    gprod = 30'(gx) * 30'(RECIP70);
    h     = hprod[23:20];
    g     = gprod[27:20];
    r     = 8'd255 - g;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid) begin
      result.status     <= req.status;
      result.column     <= req.column;
      result.blink_dots <= req.dots;
      result.last       <= req.last;
      if (req.found) begin
        result.bar_height <= h;
        result.bar_color  <= {r[7:3], g[7:2], 5'b0};
      end else begin
        result.bar_height <= '0;
        result.bar_color  <= '0;
      end
    end
  end

endmodule

>>> rtl/peer_rssi_tracker_bar_display_core.sv
// Top level: command sequencer, configuration registers, peer table and result stage.
//
// Receive commands run a scan over the peer table, one entry per cycle. A new
// or rejected-for-full peer keeps busy high for the whole scan. A known peer
// ends the scan at its entry and blends its strength in S_RX_DIV. A command
// that fails the length or magic check never raises busy. Render commands take
// one pass over the table to drop stale peers, then BAR_COLUMNS ranking passes,
// each a table scan followed by an emit state, one table read per cycle.
// Each result appears for one cycle on result with result_valid high and must
// be taken then; the last one arrives in the first cycle in which busy is low.
module peer_rssi_tracker_bar_display_core
  import prbd_pkg::*;
#(
  parameter int unsigned MAX_PEERS   = DefMaxPeers,
  parameter int unsigned BAR_COLUMNS = DefBarColumns,
  parameter int unsigned BAR_HEIGHT  = DefBarHeight
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  item_t       item,
  output logic        result_valid,
  output result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IW = $clog2(MAX_PEERS);
  localparam int unsigned CW = $clog2(BAR_COLUMNS + 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_RX_SCAN = 3'd1;
  localparam logic [2:0] S_RX_DIV  = 3'd2;
  localparam logic [2:0] S_PRUNE   = 3'd3;
  localparam logic [2:0] S_RANK    = 3'd4;
  localparam logic [2:0] S_EMIT    = 3'd5;

  logic [2:0]  state;
  logic [31:0] expire_time_ms;
  logic [3:0]  keep_tenths;

  item_t                item_q;
  logic [IW-1:0]        idx;
  logic                 free_found;
  logic [IW-1:0]        free_idx;
  logic signed [11:0]   mix;
  logic                 any_live;
  logic                 best_found;
  logic [IW-1:0]        best_idx;
  logic signed [7:0]    best_s;
  logic [47:0]          best_a;
  logic [MAX_PEERS-1:0] taken;
  logic [CW-1:0]        col;
  logic                 dots_q;
  logic                 blink;

  logic                 rd_valid;
  logic [47:0]          rd_addr;
  logic signed [7:0]    rd_strength;
  logic [31:0]          rd_seen;
  tbl_wr_t              wr;
  logic [IW-1:0]        wr_idx;
  logic signed [7:0]    wr_strength;
  col_req_t             req;

  logic                 accept;
  logic                 idx_last;
  logic                 hit;
  logic                 expired;
  logic                 any_next;
  logic                 cand;
  logic                 cfg_wr;
  logic [3:0]           keep_eff;
  logic signed [7:0]    sample;
  logic signed [11:0]   mix_next;
  logic [10:0]          mix_abs;
  logic [23:0]          quot_prod;
  logic [7:0]           quot;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign idx_last = (idx == IW'(MAX_PEERS - 1));
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      expire_time_ms <= EXPIRE_RESET;
      keep_tenths    <= KEEP_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_EXPIRE: expire_time_ms <= pwdata;
        REG_KEEP:   keep_tenths    <= pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_EXPIRE: prdata = expire_time_ms;
      REG_KEEP:   prdata = {28'b0, keep_tenths};
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    keep_eff  = (keep_tenths > KEEP_MAX) ? KEEP_MAX : keep_tenths;
    sample    = item_q.rssi_valid ? item_q.rssi_sample : 8'sd0;
    mix_next  = $signed({8'b0, keep_eff}) * 12'(rd_strength)
              + $signed({8'b0, 4'(KEEP_MAX - keep_eff)}) * 12'(sample);
    mix_abs   = mix[11] ? 11'(-mix) : 11'(mix);
    quot_prod = 24'(mix_abs) * 24'(RECIP10);
    quot      = mix[11] ? 8'(-quot_prod[23:16]) : quot_prod[23:16];
    hit       = rd_valid && (rd_addr == item_q.src_mac);
    expired   = rd_valid && ((item_q.now_ms - rd_seen) > expire_time_ms);
    any_next  = any_live || (rd_valid && !expired);
    cand      = rd_valid && !taken[idx] &&
                (!best_found || (rd_strength > best_s) ||
                 ((rd_strength == best_s) && (rd_addr < best_a)));
  end

  always_comb begin
    wr          = '0;
    wr_idx      = idx;
    wr_strength = sample;
    req         = '0;
    req.status  = ST_COLUMN;
    req.last    = 1'b1;
    case (state)
      S_IDLE: begin
        if (accept && !item.cmd) begin
          if (item.packet_length < MIN_LENGTH) begin
            req.valid  = 1'b1;
            req.status = ST_TOO_SHORT;
          end else if (item.magic_word != MAGIC_VALUE) begin
            req.valid  = 1'b1;
            req.status = ST_BAD_MAGIC;
          end
        end
      end
      S_RX_SCAN: begin
        if (!hit && idx_last) begin
          req.valid = 1'b1;
          if (free_found || !rd_valid) begin
            wr.insert  = 1'b1;
            wr_idx     = free_found ? free_idx : idx;
            req.status = ST_INSERTED;
          end else begin
            req.status = ST_FULL;
          end
        end
      end
      S_RX_DIV: begin
        wr.update   = 1'b1;
        wr_strength = quot;
        req.valid   = 1'b1;
        req.status  = ST_UPDATED;
      end
      S_PRUNE: begin
        wr.clear = expired;
      end
      S_EMIT: begin
        req.valid    = 1'b1;
        req.found    = best_found;
        req.strength = best_s;
        req.column   = 3'(col);
        req.dots     = dots_q;
        req.last     = (col == CW'(BAR_COLUMNS - 1));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      blink <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (item.cmd) begin
              state <= S_PRUNE;
            end else if (item.packet_length >= MIN_LENGTH && item.magic_word == MAGIC_VALUE) begin
              state <= S_RX_SCAN;
            end
          end
        end
        S_RX_SCAN: begin
          if (hit) begin
            state <= S_RX_DIV;
          end else if (idx_last) begin
            state <= S_IDLE;
          end
        end
        S_RX_DIV: state <= S_IDLE;
        S_PRUNE: begin
          if (idx_last) begin
            state <= S_RANK;
            if (!any_next) begin
              blink <= !blink;
            end
          end
        end
        S_RANK: begin
          if (idx_last) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          state <= (col == CW'(BAR_COLUMNS - 1)) ? S_IDLE : S_RANK;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        item_q     <= item;
        idx        <= '0;
        free_found <= 1'b0;
        any_live   <= 1'b0;
        best_found <= 1'b0;
        taken      <= '0;
        col        <= '0;
      end
      S_RX_SCAN: begin
        if (hit) begin
          mix <= mix_next;
        end else begin
          idx <= idx + 1'b1;
          if (!rd_valid && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= idx;
          end
        end
      end
      S_PRUNE: begin
        idx      <= idx_last ? '0 : idx + 1'b1;
        any_live <= any_next;
        if (idx_last) begin
          dots_q <= !any_next && !blink;
        end
      end
      S_RANK: begin
        idx <= idx_last ? '0 : idx + 1'b1;
        if (cand) begin
          best_found <= 1'b1;
          best_idx   <= idx;
          best_s     <= rd_strength;
          best_a     <= rd_addr;
        end
      end
      S_EMIT: begin
        if (best_found) begin
          taken[best_idx] <= 1'b1;
        end
        best_found <= 1'b0;
        col        <= col + 1'b1;
      end
      default: begin
      end
    endcase
  end

  prbd_table #(
    .MAX_PEERS(MAX_PEERS)
  ) u_table (
    .clk        (clk),
    .rst        (rst),
    .rd_idx     (idx),
    .rd_valid   (rd_valid),
    .rd_addr    (rd_addr),
    .rd_strength(rd_strength),
    .rd_seen    (rd_seen),
    .wr         (wr),
    .wr_idx     (wr_idx),
    .wr_addr    (item_q.src_mac),
    .wr_strength(wr_strength),
    .wr_seen    (item_q.now_ms)
  );

  prbd_colbar #(
    .BAR_HEIGHT(BAR_HEIGHT)
  ) u_colbar (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .result_valid(result_valid),
    .result      (result)
  );

`ifndef SYNTH
  a_accept_answers: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy || result_valid))
    else $error("accepted command neither busy nor answered");

  a_rx_single: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status != ST_COLUMN) |-> (result.last && !busy))
    else $error("receive result not single and final");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last) |-> !busy)
    else $error("final result while still busy");
`endif

endmodule

>>> verif/peer_rssi_tracker_bar_display_core_tb.sv
// Testbench for the peer signal-strength tracker: table updates, expiry and bar rendering.
module peer_rssi_tracker_bar_display_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import prbd_pkg::*;

  localparam int NPEER  = 16;
  localparam int NCOL   = 8;
  localparam int ITEM_W = $bits(item_t);

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  item_t       item = '0;
  logic        result_valid;
  result_t     result;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  peer_rssi_tracker_bar_display_core u_top (
    .clk, .rst, .start, .busy, .item, .result_valid, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #6 clk = ~clk;

  // predictor state
  logic [31:0]       pm_expire;
  logic [3:0]        pm_keep;
  logic              pm_valid [NPEER];
  logic [47:0]       pm_addr [NPEER];
  logic signed [7:0] pm_str [NPEER];
  logic [31:0]       pm_seen [NPEER];
  logic              pm_blink;

  item_t   pending_items[$];
  result_t expected_results[$];
  int      errors = 0;
  int      n_results = 0;
  int      n_render = 0;
  int      n_sent = 0;
  bit      drv_enable = 1'b0;

  function automatic result_t column_result(int k, logic signed [7:0] s, bit found, bit dots);
    result_t r;
    int c, g;
    r = '0;
    r.status = ST_COLUMN;
    r.column = 3'(k);
    r.blink_dots = dots;
    r.last = (k == NCOL - 1);
    if (found) begin
      c = s;
      if (c < -100) c = -100;
      if (c > -30) c = -30;
      r.bar_height = 4'(((c + 100) * 8) / 70);
      g = ((c + 100) * 255) / 70;
      r.bar_color = 16'((((255 - g) & 'hF8) << 8) | ((g & 'hFC) << 3));
    end
    return r;
  endfunction

  task automatic predict_item(item_t it);
    result_t r;
    int i, k, best, freeslot, cnt, keep, mix, smp;
    bit taken [NPEER];
    bit dots;
    r = '0;
    r.last = 1'b1;
    if (it.cmd == 1'b0) begin
      smp = it.rssi_valid ? int'(it.rssi_sample) : 0;
      freeslot = -1;
      if (it.packet_length < MIN_LENGTH) r.status = ST_TOO_SHORT;
      else if (it.magic_word != MAGIC_VALUE) r.status = ST_BAD_MAGIC;
      else begin
        r.status = ST_FULL;
        for (i = 0; i < NPEER; i++) begin
          if (r.status == ST_FULL && pm_valid[i] && pm_addr[i] == it.src_mac) begin
            keep = (pm_keep > 10) ? 10 : pm_keep;
            mix = keep * int'(pm_str[i]) + (10 - keep) * smp;
            pm_str[i] = 8'(mix / 10);
            pm_seen[i] = it.now_ms;
            r.status = ST_UPDATED;
          end
          if (!pm_valid[i] && freeslot < 0) freeslot = i;
        end
        if (r.status == ST_FULL && freeslot >= 0) begin
          pm_valid[freeslot] = 1'b1;
          pm_addr[freeslot] = it.src_mac;
          pm_str[freeslot] = 8'(smp);
          pm_seen[freeslot] = it.now_ms;
          r.status = ST_INSERTED;
        end
      end
      expected_results = {expected_results, r};
    end else begin
      cnt = 0;
      dots = 1'b0;
      for (i = 0; i < NPEER; i++) begin
        if (pm_valid[i] && (it.now_ms - pm_seen[i]) > pm_expire) pm_valid[i] = 1'b0;
        if (pm_valid[i]) cnt++;
        taken[i] = 1'b0;
      end
      if (cnt == 0) begin
        pm_blink = !pm_blink;
        dots = pm_blink;
      end
      for (k = 0; k < NCOL; k++) begin
        best = -1;
        for (i = 0; i < NPEER; i++) begin
          if (!pm_valid[i] || taken[i]) continue;
          if (best < 0 || pm_str[i] > pm_str[best] ||
              (pm_str[i] == pm_str[best] && pm_addr[i] < pm_addr[best])) best = i;
        end
        if (best >= 0) begin
          taken[best] = 1'b1;
          expected_results = {expected_results,
                              column_result(k, pm_str[best], 1'b1, dots)};
        end else begin
          expected_results = {expected_results, column_result(k, 8'sd0, 1'b0, dots)};
        end
      end
    end
  endtask

  // driver: bursts with random gaps
  int gap_left = 0, burst_left = 0;
  always @(posedge clk) begin
    if (rst || !drv_enable) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      predict_item(item);
      n_sent++;
      if (item.cmd) n_render++;
      start <= 1'b0;
      if (burst_left > 0) burst_left <= burst_left - 1;
      else begin
        burst_left <= $urandom_range(0, 6);
        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
      end
    end else if (!start && gap_left > 0) begin
      gap_left <= gap_left - 1;
    end else if (!start && pending_items.size() > 0) begin
      item <= pending_items.pop_front();
      start <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t e;
    if (!rst && result_valid) begin
      n_results++;
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer %p", result);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (result.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, result.status); errors++;
        end
        if (result.column !== e.column) begin
          $error("column exp %0d got %0d", e.column, result.column); errors++;
        end
        if (result.bar_height !== e.bar_height) begin
          $error("bar_height exp %0d got %0d", e.bar_height, result.bar_height); errors++;
        end
        if (result.bar_color !== e.bar_color) begin
          $error("bar_color exp %h got %h", e.bar_color, result.bar_color); errors++;
        end
        if (result.blink_dots !== e.blink_dots) begin
          $error("blink_dots exp %0d got %0d", e.blink_dots, result.blink_dots); errors++;
        end
        if (result.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, result.last); errors++;
        end
      end
    end
  end

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == 3'd0) pm_expire = data;
    else if (addr == 3'd4) pm_keep = data[3:0];
  endtask

  task automatic drain();
    @(posedge clk);
    while (start || pending_items.size() > 0 || busy || expected_results.size() > 0)
      @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  function automatic item_t make_rx(logic [31:0] now, logic [47:0] mac, logic signed [7:0] s);
    item_t it;
    it.cmd = 1'b0;
    it.now_ms = now;
    it.src_mac = mac;
    it.rssi_valid = 1'b1;
    it.rssi_sample = s;
    it.packet_length = 8'($urandom_range(14, 250));
    it.magic_word = MAGIC_VALUE;
    return it;
  endfunction

  function automatic item_t make_render(logic [31:0] now);
    item_t it;
    it = item_t'(ITEM_W'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    it.cmd = 1'b1;
    it.now_ms = now;
    return it;
  endfunction

  logic [47:0] mac_pool [6];

  initial begin
    item_t it;
    logic [31:0] clock_ms;
    int ph, n, r;
    for (int i = 0; i < NPEER; i++) begin
      pm_valid[i] = 1'b0; pm_addr[i] = '0; pm_str[i] = '0; pm_seen[i] = '0;
    end
    pm_expire = EXPIRE_RESET;
    pm_keep = KEEP_RESET;
    pm_blink = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    drv_enable = 1'b1;

    // directed: empty render, checks, extremes, full table, ties
    pending_items = {pending_items, make_render(32'd0)};
    pending_items = {pending_items, make_render(32'd5)};
    it = make_rx(32'd10, 48'hFFFF_FFFF_FFFF, 8'sd127); it.packet_length = 8'd13;
    pending_items = {pending_items, it};
    it = make_rx(32'd10, 48'h0, -8'sd128); it.packet_length = 8'd0;
    pending_items = {pending_items, it};
    it = make_rx(32'd10, 48'h1, 8'sd0); it.magic_word = ~MAGIC_VALUE;
    pending_items = {pending_items, it};
    pending_items = {pending_items, make_rx(32'd20, 48'hFFFF_FFFF_FFFF, 8'sd127)};
    pending_items = {pending_items, make_rx(32'd20, 48'h0, -8'sd128)};
    it = make_rx(32'd21, 48'h0, 8'sd10); it.rssi_valid = 1'b0;
    pending_items = {pending_items, it};
    for (int i = 0; i < 15; i++)
      pending_items = {pending_items, make_rx(32'd30, 48'h100 + 48'(i), -8'sd60)};
    pending_items = {pending_items, make_render(32'd40)};
    drain();

    // expire all, then phased random runs
    reg_write(3'd0, 32'd0);
    reg_write(3'd4, 32'd15);
    pending_items = {pending_items, make_render(32'd41)};
    pending_items = {pending_items, make_render(32'hFFFF_FFFF)};
    drain();

    clock_ms = 32'hFFFF_F000;
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin reg_write(3'd0, 32'd10000); reg_write(3'd4, 32'd7); end
        1: begin reg_write(3'd0, 32'hFFFF_FFFF); reg_write(3'd4, 32'd0); end
        2: begin reg_write(3'd0, 32'd300); reg_write(3'd4, 32'd10); end
        3: begin reg_write(3'd0, 32'd2000); reg_write(3'd4, 32'd11); end
        4: begin reg_write(3'd0, $urandom); reg_write(3'd4, $urandom_range(0, 15)); end
        default: begin reg_write(3'd0, 32'd1000); reg_write(3'd4, 32'd5); end
      endcase
      for (int i = 0; i < 6; i++) mac_pool[i] = 48'({$urandom, $urandom});
      if (ph == 1) mac_pool[1] = mac_pool[0];
      for (n = 0; n < 60; n++) begin
        clock_ms += $urandom_range(0, 400);
        r = $urandom_range(0, 99);
        if (r < 18) it = make_render(clock_ms);
        else if (r < 80) begin
          it = make_rx(clock_ms, mac_pool[$urandom_range(0, 5)],
                       8'($urandom_range(0, 255)));
          if ($urandom_range(0, 9) == 0) it.rssi_valid = 1'b0;
        end else if (r < 90) begin
          it = make_rx(clock_ms, 48'({$urandom, $urandom}), 8'($urandom));
        end else begin
          it = item_t'(ITEM_W'({$urandom, $urandom, $urandom, $urandom, $urandom}));
          it.cmd = 1'b0;
          it.now_ms = clock_ms;
        end
        pending_items = {pending_items, it};
      end
      drain();
    end

    $display("Sent %0d command transfers (%0d renders) under six register settings,",
             n_sent, n_render);
    $display("checked %0d result transfers.", n_results);
    if (errors == 0) $display("PASS peer_rssi_tracker_bar_display_core");
    else $display("FAIL peer_rssi_tracker_bar_display_core");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL peer_rssi_tracker_bar_display_core");
    $finish;
  end

endmodule
